>>> design/csc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSC package
// Shared types and constants of the cycling speed and cadence decoder.
// ----------------------------------------------------------------------------
package csc_pkg;

  localparam int unsigned WHEEL_TICKS_DEFAULT = 1024;
  localparam int unsigned CRANK_TICKS_DEFAULT = 1024;

  localparam int unsigned CIRC_W    = 12;
  localparam int unsigned MUL_W     = 32;
  localparam int unsigned DEN_W     = 21;
  localparam int unsigned SCALE_W   = 22;
  localparam int unsigned RESULT_W  = 16;

  localparam logic [CIRC_W-1:0] CIRC_RESET = 12'd1920;

  localparam int unsigned SPEED_MUL   = 9;
  localparam int unsigned SPEED_DIV   = 25;
  localparam int unsigned CADENCE_MUL = 60;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [RESULT_W-1:0] speed_centi_kph;
    logic [RESULT_W-1:0] cadence_rpm;
    logic                speed_updated;
    logic                cadence_updated;
    logic                length_error;
  } out_item_t;

  typedef struct packed {
    logic [CIRC_W-1:0] wheel_circumference_mm;
  } cfg_item_t;

endpackage

>>> design/csc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSC stream interface
// Valid and ready channel that carries one payload per transfer.
// ----------------------------------------------------------------------------
interface csc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> design/csc_measurement_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSC measurement decoder
// Assembles a cycling speed and cadence notification byte by byte and derives
// speed and cadence with one shared bit-serial multiply and divide unit.
//
//   Channel  Direction  Payload
//   in_if    sink       data_byte, last_byte
//   out_if   source     speed, cadence, update flags, length error
//   cfg_if   sink       wheel_circumference_mm
//
// A byte without the last mark leaves the input ready. A last byte holds the
// input while speed or cadence, as needed, is recomputed by the 32 shift-add
// steps and 16 restoring division steps of the shared unit (no division when
// the quotient saturates). Reset is synchronous and clears the control state,
// not the arithmetic or payload registers. A result that waits on out_if does
// not stop the next notification's bytes; after its last byte, the input waits until that result is taken.
// ----------------------------------------------------------------------------
module csc_measurement_decoder_top #(
  parameter int unsigned WHEEL_TICKS_PER_SECOND = csc_pkg::WHEEL_TICKS_DEFAULT,
  parameter int unsigned CRANK_TICKS_PER_SECOND = csc_pkg::CRANK_TICKS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  csc_stream_if.sink   in_if,
  csc_stream_if.source out_if,
  csc_stream_if.sink   cfg_if
);
  import csc_pkg::*;

  localparam logic [SCALE_W-1:0] SPEED_SCALE   = SCALE_W'(SPEED_MUL * WHEEL_TICKS_PER_SECOND);
  localparam logic [SCALE_W-1:0] CADENCE_SCALE = SCALE_W'(CADENCE_MUL * CRANK_TICKS_PER_SECOND);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_W_SET = 3'd1;
  localparam logic [2:0] S_C_SET = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_STORE = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [3:0]          pos_r, pos_nxt;
  logic [7:0]          flags_r, flags_nxt;
  logic [31:0]         wrevs_r, wrevs_nxt;
  logic [15:0]         wtime_r, wtime_nxt;
  logic [15:0]         crevs_r, crevs_nxt;
  logic [15:0]         ctime_r, ctime_nxt;
  logic [31:0]         pwrevs_r, pwrevs_nxt;
  logic [15:0]         pwtime_r, pwtime_nxt;
  logic [15:0]         pcrevs_r, pcrevs_nxt;
  logic [15:0]         pctime_r, pctime_nxt;
  logic [RESULT_W-1:0] hspeed_r, hspeed_nxt;
  logic [RESULT_W-1:0] hcad_r, hcad_nxt;
  logic [CIRC_W-1:0]   circ_r;
  logic                err_r, err_nxt;
  logic                sp_up_r, sp_up_nxt;
  logic                cd_up_r, cd_up_nxt;
  logic                phase_r, phase_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic [MUL_W-1:0]    k_r, k_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [MUL_W-1:0]    hi_r, hi_nxt;
  logic [MUL_W-1:0]    lo_r, lo_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  logic                in_fire;
  logic [7:0]          b;
  logic [3:0]          idx;
  logic [3:0]          cidx;
  logic                placed;
  logic [4:0]          count;
  logic [4:0]          expected;
  logic [15:0]         wdt;
  logic [15:0]         cdr;
  logic [15:0]         cdt;
  logic [MUL_W:0]      sum;
  logic [47:0]         numhi;
  logic [DEN_W:0]      trial;
  logic                ge;
  logic                out_load;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;
  assign in_fire = in_if.valid && in_if.ready;
  assign b       = in_if.payload.data_byte;
  assign wdt     = wtime_r - pwtime_r;
  assign cdr     = crevs_r - pcrevs_r;
  assign cdt     = ctime_r - pctime_r;

  // Byte placement into the staging fields.
  always_comb begin
    idx       = pos_r - 4'd1;
    cidx      = idx;
    placed    = 1'b0;
    flags_nxt = flags_r;
    wrevs_nxt = wrevs_r;
    wtime_nxt = wtime_r;
    crevs_nxt = crevs_r;
    ctime_nxt = ctime_r;
    if (in_fire) begin
      if (pos_r == 4'd0) begin
        flags_nxt = b;
      end else begin
        if (flags_r[0]) begin
          if (idx < 4'd4) begin
            wrevs_nxt[{idx[1:0], 3'b000} +: 8] = b;
            placed = 1'b1;
          end else if (idx < 4'd6) begin
            wtime_nxt[{idx[0], 3'b000} +: 8] = b;
            placed = 1'b1;
          end
          cidx = idx - 4'd6;
        end
        if (!placed && flags_r[1]) begin
          if (cidx < 4'd2) begin
            crevs_nxt[{cidx[0], 3'b000} +: 8] = b;
          end else if (cidx < 4'd4) begin
            ctime_nxt[{cidx[0], 3'b000} +: 8] = b;
          end
        end
      end
    end
    count    = {1'b0, pos_r} + 5'd1;
    expected = 5'd1 + (flags_nxt[0] ? 5'd6 : 5'd0) + (flags_nxt[1] ? 5'd4 : 5'd0);
  end

  // Sequencer and shared multiply and divide unit.
  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    pwrevs_nxt   = pwrevs_r;
    pwtime_nxt   = pwtime_r;
    pcrevs_nxt   = pcrevs_r;
    pctime_nxt   = pctime_r;
    hspeed_nxt   = hspeed_r;
    hcad_nxt     = hcad_r;
    err_nxt      = err_r;
    sp_up_nxt    = sp_up_r;
    cd_up_nxt    = cd_up_r;
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    k_nxt        = k_r;
    den_nxt      = den_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    out_load     = 1'b0;
    sum          = {1'b0, hi_r} + (lo_r[0] ? {1'b0, k_r} : {(MUL_W + 1){1'b0}});
    numhi        = {hi_r, lo_r[31:16]};
    trial        = {hi_r[DEN_W-1:0], lo_r[15]};
    ge           = (trial >= {1'b0, den_r});
    out_item_nxt = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_if.payload.last_byte) begin
            pos_nxt   = 4'd0;
            err_nxt   = (count != expected);
            sp_up_nxt = 1'b0;
            cd_up_nxt = 1'b0;
            state_nxt = S_W_SET;
          end else begin
            pos_nxt = (pos_r == 4'd15) ? 4'd15 : pos_r + 4'd1;
          end
        end
      end
      S_W_SET: begin
        if (!err_r && flags_r[0] && (wtime_r != pwtime_r)) begin
          k_nxt     = MUL_W'(circ_r) * MUL_W'(SPEED_SCALE);
          den_nxt   = DEN_W'(wdt) * DEN_W'(SPEED_DIV);
          hi_nxt    = '0;
          lo_nxt    = wrevs_r - pwrevs_r;
          cnt_nxt   = 5'd31;
          phase_nxt = 1'b0;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_C_SET;
        end
      end
      S_C_SET: begin
        if (!err_r && flags_r[1] && (ctime_r != pctime_r)) begin
          k_nxt     = MUL_W'(CADENCE_SCALE);
          den_nxt   = DEN_W'(cdt);
          hi_nxt    = '0;
          lo_nxt    = MUL_W'(cdr);
          cnt_nxt   = 5'd31;
          phase_nxt = 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MUL: begin
        hi_nxt  = sum[MUL_W:1];
        lo_nxt  = {sum[0], lo_r[MUL_W-1:1]};
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (numhi >= 48'(den_r)) begin
          lo_nxt[15:0] = 16'hFFFF;
          state_nxt    = S_STORE;
        end else begin
          hi_nxt    = MUL_W'(numhi[DEN_W-1:0]);
          cnt_nxt   = 5'd15;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        hi_nxt       = ge ? MUL_W'(DEN_W'(trial - {1'b0, den_r})) : MUL_W'(trial[DEN_W-1:0]);
        lo_nxt[15:0] = {lo_r[14:0], ge};
        cnt_nxt      = cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        if (!phase_r) begin
          hspeed_nxt = lo_r[15:0];
          pwrevs_nxt = wrevs_r;
          pwtime_nxt = wtime_r;
          sp_up_nxt  = 1'b1;
          state_nxt  = S_C_SET;
        end else begin
          hcad_nxt   = lo_r[15:0];
          pcrevs_nxt = crevs_r;
          pctime_nxt = ctime_r;
          cd_up_nxt  = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_if.ready) begin
          out_load                     = 1'b1;
          out_item_nxt.speed_centi_kph = hspeed_r;
          out_item_nxt.cadence_rpm     = hcad_r;
          out_item_nxt.speed_updated   = sp_up_r;
          out_item_nxt.cadence_updated = cd_up_r;
          out_item_nxt.length_error    = err_r;
          state_nxt                    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_if.ready) || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      flags_r     <= '0;
      wrevs_r     <= '0;
      wtime_r     <= '0;
      crevs_r     <= '0;
      ctime_r     <= '0;
      pwrevs_r    <= '0;
      pwtime_r    <= '0;
      pcrevs_r    <= '0;
      pctime_r    <= '0;
      hspeed_r    <= '0;
      hcad_r      <= '0;
      circ_r      <= CIRC_RESET;
      err_r       <= 1'b0;
      sp_up_r     <= 1'b0;
      cd_up_r     <= 1'b0;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      flags_r     <= flags_nxt;
      wrevs_r     <= wrevs_nxt;
      wtime_r     <= wtime_nxt;
      crevs_r     <= crevs_nxt;
      ctime_r     <= ctime_nxt;
      pwrevs_r    <= pwrevs_nxt;
      pwtime_r    <= pwtime_nxt;
      pcrevs_r    <= pcrevs_nxt;
      pctime_r    <= pctime_nxt;
      hspeed_r    <= hspeed_nxt;
      hcad_r      <= hcad_nxt;
      err_r       <= err_nxt;
      sp_up_r     <= sp_up_nxt;
      cd_up_r     <= cd_up_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        circ_r <= cfg_if.payload.wheel_circumference_mm;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    den_r      <= den_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    out_item_r <= out_item_nxt;
  end

  // The partial remainder stays below the divisor through every division step.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> hi_r < MUL_W'(den_r))
    else $error("partial remainder not below divisor");

  // A result is stored only for a valid notification that carries its field.
  a_store_flag: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STORE |-> !err_r && (phase_r ? flags_r[1] : flags_r[0]))
    else $error("result stored without its field or after a length error");

  // Held results change only in the store step.
  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_STORE |=> $stable(hspeed_r) && $stable(hcad_r))
    else $error("held result changed outside the store step");

  // A length error never reports an update.
  a_err_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.ready && out_if.payload.length_error
      |-> !out_if.payload.speed_updated && !out_if.payload.cadence_updated)
    else $error("update reported together with a length error");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSC measurement decoder testbench
// Sends cycling speed and cadence notifications byte by byte, as directed
// frames first and then as random frames, truncated frames, overlong frames
// and byte noise. A scoreboard predicts every result from the accepted bytes
// and checks the results field by field. Both sides idle and stall at random.
// The circumference register is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  import csc_pkg::*;

  localparam int unsigned WHEEL_TICKS   = WHEEL_TICKS_DEFAULT;
  localparam int unsigned CRANK_TICKS   = CRANK_TICKS_DEFAULT;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          PHASE_BYTES   = 125;
  localparam int          NUM_PHASES    = 6;
  localparam time         RUN_LIMIT     = 8_000_000;

  typedef bit [7:0] frame_t[$];

  class csc_decoder_scoreboard;
    bit [11:0] circ_mm = CIRC_RESET;
    bit [3:0]  byte_pos;
    bit [7:0]  flags;
    bit [31:0] wheel_revs;
    bit [15:0] wheel_time;
    bit [15:0] crank_revs;
    bit [15:0] crank_time;
    bit [31:0] prev_wheel_revs;
    bit [15:0] prev_wheel_time;
    bit [15:0] prev_crank_revs;
    bit [15:0] prev_crank_time;
    bit [15:0] held_speed;
    bit [15:0] held_cadence;
    out_item_t pending[$];
    int errors;
    int results;
    int length_errors;
    int speed_updates;
    int cadence_updates;

    function void place_byte(int idx, bit [7:0] b);
      if (flags[0]) begin
        if (idx < 4) begin
          wheel_revs[idx*8 +: 8] = b;
          return;
        end
        if (idx < 6) begin
          wheel_time[(idx-4)*8 +: 8] = b;
          return;
        end
        idx -= 6;
      end
      if (flags[1]) begin
        if (idx < 2) crank_revs[idx*8 +: 8] = b;
        else if (idx < 4) crank_time[(idx-2)*8 +: 8] = b;
      end
    endfunction

    function bit [15:0] sat16(bit [63:0] v);
      return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function void take_byte(bit [7:0] b, bit last);
      bit [3:0]  p;
      int        count;
      int        needed;
      bit        err;
      bit        sp_up;
      bit        cd_up;
      bit [31:0] dwr;
      bit [15:0] dcr;
      bit [15:0] dt;
      bit [63:0] num;
      out_item_t want;
      p = byte_pos;
      sp_up = 1'b0;
      cd_up = 1'b0;
      if (p == 0) flags = b;
      else place_byte(int'(p) - 1, b);
      if (!last) begin
        byte_pos = (p < 15) ? p + 4'd1 : 4'd15;
        return;
      end
      byte_pos = 0;
      count = int'(p) + 1;
      needed = 1 + (flags[0] ? 6 : 0) + (flags[1] ? 4 : 0);
      err = (count != needed);
      if (!err && flags[0] && wheel_time != prev_wheel_time) begin
        dwr = wheel_revs - prev_wheel_revs;
        dt = wheel_time - prev_wheel_time;
        num = 64'(SPEED_MUL) * 64'(WHEEL_TICKS) * 64'(circ_mm) * 64'(dwr);
        held_speed = sat16(num / (64'(SPEED_DIV) * 64'(dt)));
        prev_wheel_revs = wheel_revs;
        prev_wheel_time = wheel_time;
        sp_up = 1'b1;
      end
      if (!err && flags[1] && crank_time != prev_crank_time) begin
        dcr = crank_revs - prev_crank_revs;
        dt = crank_time - prev_crank_time;
        num = 64'(CADENCE_MUL) * 64'(CRANK_TICKS) * 64'(dcr);
        held_cadence = sat16(num / 64'(dt));
        prev_crank_revs = crank_revs;
        prev_crank_time = crank_time;
        cd_up = 1'b1;
      end
      want.speed_centi_kph = held_speed;
      want.cadence_rpm = held_cadence;
      want.speed_updated = sp_up;
      want.cadence_updated = cd_up;
      want.length_error = err;
      pending.push_back(want);
      length_errors += err;
      speed_updates += sp_up;
      cadence_updates += cd_up;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void compare_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %p", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      results++;
      check_field("speed_centi_kph", want.speed_centi_kph, got.speed_centi_kph);
      check_field("cadence_rpm", want.cadence_rpm, got.cadence_rpm);
      check_field("speed_updated", want.speed_updated, got.speed_updated);
      check_field("cadence_updated", want.cadence_updated, got.cadence_updated);
      check_field("length_error", want.length_error, got.length_error);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  csc_stream_if #(.T(in_item_t))  in_ch ();
  csc_stream_if #(.T(out_item_t)) out_ch ();
  csc_stream_if #(.T(cfg_item_t)) cfg_ch ();

  csc_measurement_decoder_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  csc_decoder_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_req;
  int bytes_sent;
  int frames_sent;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.compare_result(out_ch.payload);
  end

  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
      end
    end
  end

  task automatic send_byte(bit [7:0] b, bit last);
    int gap;
    in_item_t item;
    gap = 0;
    while (tx_idle_pct > 0 && $urandom_range(99, 0) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.data_byte = b;
    item.last_byte = last;
    in_ch.valid <= 1'b1;
    in_ch.payload <= item;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(frame_t f);
    foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    frames_sent++;
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_circumference(bit [11:0] value);
    cfg_item_t item;
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    item.wheel_circumference_mm = value;
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= item;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.circ_mm = value;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_measurement(int shape);
    frame_t    f;
    bit        wheel;
    bit        crank;
    bit [31:0] wr;
    bit [15:0] wt;
    bit [15:0] cr;
    bit [15:0] ct;
    int        r;
    int        n;
    wheel = ($urandom_range(9, 0) < 7);
    crank = ($urandom_range(9, 0) < 7);
    r = $urandom_range(99, 0);
    if (r < 8) begin
      wt = sb.prev_wheel_time;
      wr = $urandom;
    end else if (r < 75) begin
      wt = sb.prev_wheel_time + 16'($urandom_range(4000, 200));
      wr = sb.prev_wheel_revs + 32'($urandom_range(6, 0));
    end else if (r < 88) begin
      wt = sb.prev_wheel_time + 16'($urandom_range(65535, 1));
      wr = $urandom;
    end else begin
      wt = sb.prev_wheel_time + 16'($urandom_range(20, 1));
      wr = sb.prev_wheel_revs + 32'($urandom_range(3, 1));
    end
    r = $urandom_range(99, 0);
    if (r < 8) begin
      ct = sb.prev_crank_time;
      cr = 16'($urandom);
    end else if (r < 80) begin
      ct = sb.prev_crank_time + 16'($urandom_range(3000, 300));
      cr = sb.prev_crank_revs + 16'($urandom_range(4, 0));
    end else begin
      ct = sb.prev_crank_time + 16'($urandom_range(65535, 1));
      cr = 16'($urandom);
    end
    f.push_back({($urandom_range(3, 0) == 0) ? 6'($urandom) : 6'd0, crank, wheel});
    if (wheel) begin
      for (int i = 0; i < 4; i++) f.push_back(wr[i*8 +: 8]);
      for (int i = 0; i < 2; i++) f.push_back(wt[i*8 +: 8]);
    end
    if (crank) begin
      for (int i = 0; i < 2; i++) f.push_back(cr[i*8 +: 8]);
      for (int i = 0; i < 2; i++) f.push_back(ct[i*8 +: 8]);
    end
    if (shape == 1 && f.size() > 1) begin
      n = $urandom_range(f.size() - 1, 1);
      repeat (n) void'(f.pop_back());
    end else if (shape != 0) begin
      n = ($urandom_range(3, 0) == 0) ? $urandom_range(14, 6) : $urandom_range(3, 1);
      repeat (n) f.push_back(8'($urandom));
    end
    send_frame(f);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(20, 1);
    for (int i = 0; i < n; i++) begin
      send_byte(8'($urandom), (i == n - 1) || ($urandom_range(3, 0) == 0));
    end
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    frame_t    f;
    bit [11:0] circ_plan[NUM_PHASES];
    int        goal;
    int        r;
    bit        held;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.payload <= '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    f = {8'hFC};
    send_frame(f);
    f = {8'h02, 8'h03, 8'h00, 8'h00, 8'h04};
    send_frame(f);
    f = {8'h03, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h04};
    send_frame(f);
    f = {8'h01, 8'h10};
    send_frame(f);
    f = {8'h00, 8'h55};
    send_frame(f);
    f = {8'h02, 8'h01, 8'h00, 8'h00, 8'h00};
    send_frame(f);

    circ_plan = '{12'd100, 12'd4000, 12'd0, 12'd4095,
                  12'($urandom_range(4000, 100)), 12'd2096};
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_circumference(circ_plan[ph]);
      tx_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 52 : 0;
      rx_idle_pct = (ph < 2) ? 52 : (ph < 4) ? 30 : 0;
      goal = bytes_sent + PHASE_BYTES;
      held = 1'b0;
      while (bytes_sent < goal) begin
        if (!held && bytes_sent > goal - PHASE_BYTES / 2) begin
          held = 1'b1;
          if (ph == 1 || ph == 3) hold_req++;
          if (ph == 4) wait_drain();
        end
        r = $urandom_range(99, 0);
        if (r < 72) send_measurement(0);
        else if (r < 82) send_measurement(1);
        else if (r < 90) send_measurement(2);
        else send_noise();
      end
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d bytes in %0d frames under %0d circumference settings.",
             bytes_sent, frames_sent, NUM_PHASES + 1);
    $display("Checked %0d results: %0d length errors, %0d speed and %0d cadence updates.",
             sb.results, sb.length_errors, sb.speed_updates, sb.cadence_updates);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
